@@ rtl/fmg_pkg.sv @@
// ----------------------------------------------------------------------------
// Fuzzy membership grade package
// Shape codes, register indexes, grade modes and default widths shared by
// the fuzzy membership grade core.
// ----------------------------------------------------------------------------
package fmg_pkg;

  // Default widths of the sample and of the grade fraction.
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int GRADE_FRAC_BITS_DEF = 15;

  // Configuration register index port width and register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_A    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_B    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_C    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POINT_D    = 3'd4;

  // Membership shape codes.
  typedef enum logic [2:0] {
    SHAPE_LEFT_SHOULDER  = 3'd0,
    SHAPE_RIGHT_SHOULDER = 3'd1,
    SHAPE_TRIANGLE       = 3'd2,
    SHAPE_TRAPEZOID      = 3'd3,
    SHAPE_INTERVAL       = 3'd4,
    SHAPE_SINGLETON      = 3'd5
  } shape_t;

  // How the grade of an item in flight is formed at the pipeline end.
  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_SLOPE = 2'd2
  } grade_mode_t;

endpackage

@@ rtl/fuzzy_membership_grade_core.sv @@
// ----------------------------------------------------------------------------
// Fuzzy membership grade core
// Pipeline: classify stage, subtraction stage, restoring division stages
// (one quotient bit per stage) and the output register; fully pipelined.
// Throughput: one sample per cycle while out_stall does not hold the pipeline.
// Reset: rst is synchronous; it empties the pipeline and clears all
// configuration registers to zero (left shoulder, all breakpoints 0).
// ----------------------------------------------------------------------------
module fuzzy_membership_grade_core #(
  parameter int SAMPLE_WIDTH    = fmg_pkg::SAMPLE_WIDTH_DEF,
  parameter int GRADE_FRAC_BITS = fmg_pkg::GRADE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Sample channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  // Grade channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [GRADE_FRAC_BITS:0]       grade,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fmg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]        cfg_data
);
  import fmg_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int FB = GRADE_FRAC_BITS;
  localparam logic [FB:0] FULL_GRADE = {1'b1, {FB{1'b0}}};

  // Configuration registers.
  logic [2:0]           shape_kind;
  logic signed [SW-1:0] point_a;
  logic signed [SW-1:0] point_b;
  logic signed [SW-1:0] point_c;
  logic signed [SW-1:0] point_d;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= '0;
      point_a    <= '0;
      point_b    <= '0;
      point_c    <= '0;
      point_d    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAPE_KIND: shape_kind <= cfg_data[2:0];
        REG_POINT_A:    point_a    <= $signed(cfg_data);
        REG_POINT_B:    point_b    <= $signed(cfg_data);
        REG_POINT_C:    point_c    <= $signed(cfg_data);
        REG_POINT_D:    point_d    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Pipeline stage enables, from the output back to the input. A stage
  // moves when it is empty or when the stage after it moves.
  logic s0_v;
  logic out_en;
  logic s0_en;
  logic div_v  [0:FB];
  logic div_en [0:FB];

  assign out_en = !out_valid || !out_stall;

  always_comb begin
    div_en[FB] = !div_v[FB] || out_en;
    for (int j = FB - 1; j >= 0; j--) begin
      div_en[j] = !div_v[j] || div_en[j+1];
    end
  end

  assign s0_en    = !s0_v || div_en[0];
  assign in_stall = !s0_en;

  // Stage 0: classify the sample against the shape and pick the operands
  // of the distance and span subtractions.
  grade_mode_t          mode_in;
  logic signed [SW-1:0] dhi_in;
  logic signed [SW-1:0] dlo_in;
  logic signed [SW-1:0] shi_in;
  logic signed [SW-1:0] slo_in;

  always_comb begin
    mode_in = MODE_ZERO;
    dhi_in  = sample;
    dlo_in  = point_a;
    shi_in  = point_b;
    slo_in  = point_a;
    unique case (shape_kind)
      SHAPE_LEFT_SHOULDER: begin
        priority if (sample <= point_a) begin
          mode_in = MODE_FULL;
        end else if (sample >= point_b) begin
          mode_in = MODE_ZERO;
        end else begin
          mode_in = MODE_SLOPE;
          dhi_in  = point_b;
          dlo_in  = sample;
        end
      end
      SHAPE_RIGHT_SHOULDER: begin
        priority if (sample >= point_b) begin
          mode_in = MODE_FULL;
        end else if (sample <= point_a) begin
          mode_in = MODE_ZERO;
        end else begin
          mode_in = MODE_SLOPE;
        end
      end
      SHAPE_TRIANGLE: begin
        priority if (sample <= point_a || sample >= point_c) begin
          mode_in = MODE_ZERO;
        end else if (sample < point_b) begin
          mode_in = MODE_SLOPE;
        end else if (sample > point_b) begin
          mode_in = MODE_SLOPE;
          dhi_in  = point_c;
          dlo_in  = sample;
          shi_in  = point_c;
          slo_in  = point_b;
        end else begin
          mode_in = MODE_FULL;
        end
      end
      SHAPE_TRAPEZOID: begin
        priority if (sample <= point_a || sample >= point_d) begin
          mode_in = MODE_ZERO;
        end else if (sample < point_b) begin
          mode_in = MODE_SLOPE;
        end else if (sample > point_c) begin
          mode_in = MODE_SLOPE;
          dhi_in  = point_d;
          dlo_in  = sample;
          shi_in  = point_d;
          slo_in  = point_c;
        end else begin
          mode_in = MODE_FULL;
        end
      end
      SHAPE_INTERVAL: begin
        if (sample >= point_a && sample <= point_b) begin
          mode_in = MODE_FULL;
        end
      end
      SHAPE_SINGLETON: begin
        if (sample == point_a) begin
          mode_in = MODE_FULL;
        end
      end
      default: begin
        mode_in = MODE_ZERO;
      end
    endcase
  end

  grade_mode_t          s0_mode;
  logic signed [SW-1:0] s0_dhi;
  logic signed [SW-1:0] s0_dlo;
  logic signed [SW-1:0] s0_shi;
  logic signed [SW-1:0] s0_slo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_mode <= mode_in;
      s0_dhi  <= dhi_in;
      s0_dlo  <= dlo_in;
      s0_shi  <= shi_in;
      s0_slo  <= slo_in;
    end
  end

  // Stage 1: distance and span. Both are positive and below 2^SW on the
  // slope path, so the low SW bits of the widened differences are exact.
  logic [SW:0] dist_wide;
  logic [SW:0] span_wide;

  assign dist_wide = {s0_dhi[SW-1], s0_dhi} - {s0_dlo[SW-1], s0_dlo};
  assign span_wide = {s0_shi[SW-1], s0_shi} - {s0_slo[SW-1], s0_slo};

  grade_mode_t   div_mode [0:FB];
  logic [SW-1:0] div_rem  [0:FB];
  logic [SW-1:0] div_span [0:FB];
  logic [FB-1:0] div_q    [0:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (div_en[0]) begin
      div_v[0] <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (div_en[0]) begin
      div_mode[0] <= s0_mode;
      div_rem[0]  <= dist_wide[SW-1:0];
      div_span[0] <= span_wide[SW-1:0];
      div_q[0]    <= '0;
    end
  end

  // Restoring division stages, one quotient bit each, giving
  // floor(dist * 2^FB / span) after FB stages.
  for (genvar j = 1; j <= FB; j++) begin : g_div
    logic [SW:0]   trial;
    logic          take;
    logic [SW:0]   diff;

    assign trial = {div_rem[j-1], 1'b0};
    assign take  = trial >= {1'b0, div_span[j-1]};
    assign diff  = trial - {1'b0, div_span[j-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[j] <= 1'b0;
      end else if (div_en[j]) begin
        div_v[j] <= div_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (div_en[j]) begin
        div_mode[j] <= div_mode[j-1];
        div_span[j] <= div_span[j-1];
        div_rem[j]  <= take ? diff[SW-1:0] : trial[SW-1:0];
        div_q[j]    <= {div_q[j-1][FB-2:0], take};
      end
    end
  end

  // Output register: select the grade from the mode.
  logic [FB:0] grade_next;

  always_comb begin
    unique case (div_mode[FB])
      MODE_FULL:  grade_next = FULL_GRADE;
      MODE_SLOPE: grade_next = {1'b0, div_q[FB]};
      default:    grade_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_v[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      grade <= grade_next;
    end
  end

  // A delivered grade never exceeds full membership.
  a_grade_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> grade <= FULL_GRADE)
    else $error("grade above full membership");

  // The slope path only ever sees 0 < dist < span.
  a_slope_operands: assert property (@(posedge clk) disable iff (rst)
    (div_v[0] && div_mode[0] == MODE_SLOPE) |->
      (div_rem[0] != '0 && div_rem[0] < div_span[0]))
    else $error("slope operands out of range");

  // With the output register empty the whole pipeline can move.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A sample transfer lands in the first stage.
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s0_v)
    else $error("accepted sample lost at entry");

endmodule

@@ test/tb_fuzzy_membership_grade_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy membership grade core testbench
// Streams signed samples through the core under each membership shape and
// checks every grade against a behavioral predictor of the shapes. A short
// directed pass covers the corner cases. Random shapes and samples follow,
// under varying backpressure on the input side and the output side.
// ----------------------------------------------------------------------------
module tb_fuzzy_membership_grade_core;
  import fmg_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int FRAC         = GRADE_FRAC_BITS_DEF;
  localparam int PIPE_LATENCY = FRAC + 3;
  localparam int QUIET_LIMIT  = 5000;
  localparam longint FULL_GRADE = longint'(1) << FRAC;
  // Shape code with no shape behind it; the grade must read as zero.
  localparam logic [2:0] SHAPE_UNUSED = 3'd7;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic [FRAC:0]        grade;
  } pending_grade_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FRAC:0] grade;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SW-1:0] cfg_data = '0;

  // Local copy of the configuration, tracked from the register transfers.
  logic [2:0]           kind_q = '0;
  logic signed [SW-1:0] pt_a = '0;
  logic signed [SW-1:0] pt_b = '0;
  logic signed [SW-1:0] pt_c = '0;
  logic signed [SW-1:0] pt_d = '0;

  logic signed [SW-1:0] samples_pending[$];
  pending_grade_t       grades_due[$];
  int samples_queued = 0;
  int samples_taken = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int shape_pts[4] = '{0, 0, 0, 0};
  logic took_sample = 1'b0;

  fuzzy_membership_grade_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .grade     (grade),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Linear interpolation: floor(FULL * offset / span) over a positive span.
  function automatic logic [FRAC:0] ramp_grade(input longint offset, input longint span);
    if (span <= 0 || offset <= 0) return '0;
    if (offset >= span) return (FRAC+1)'(FULL_GRADE);
    return (FRAC+1)'((FULL_GRADE * offset) / span);
  endfunction

  // Expected grade of one sample under the current shape.
  function automatic logic [FRAC:0] membership_grade(input logic signed [SW-1:0] x);
    longint xs, a, b, c, d;
    xs = x;
    a = pt_a;
    b = pt_b;
    c = pt_c;
    d = pt_d;
    case (kind_q)
      SHAPE_LEFT_SHOULDER: begin
        if (xs <= a) return (FRAC+1)'(FULL_GRADE);
        if (xs >= b) return '0;
        return ramp_grade(b - xs, b - a);
      end
      SHAPE_RIGHT_SHOULDER: begin
        if (xs >= b) return (FRAC+1)'(FULL_GRADE);
        if (xs <= a) return '0;
        return ramp_grade(xs - a, b - a);
      end
      SHAPE_TRIANGLE: begin
        if (xs <= a || xs >= c) return '0;
        if (xs < b) return ramp_grade(xs - a, b - a);
        if (xs > b) return ramp_grade(c - xs, c - b);
        return (FRAC+1)'(FULL_GRADE);
      end
      SHAPE_TRAPEZOID: begin
        if (xs <= a || xs >= d) return '0;
        if (xs < b) return ramp_grade(xs - a, b - a);
        if (xs > c) return ramp_grade(d - xs, d - c);
        return (FRAC+1)'(FULL_GRADE);
      end
      SHAPE_INTERVAL: return (xs >= a && xs <= b) ? (FRAC+1)'(FULL_GRADE) : '0;
      SHAPE_SINGLETON: return (xs == a) ? (FRAC+1)'(FULL_GRADE) : '0;
      default: return '0;
    endcase
  endfunction

  // Sample driver: holds a stalled sample, otherwise offers the next one.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (in_valid && !took_sample) begin
      in_valid <= 1'b1;
    end else if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      sample <= samples_pending.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Monitor: tracks register writes, predicts each grade and checks the output.
  always @(posedge clk) begin
    pending_grade_t due;
    if (rst) begin
      took_sample <= 1'b0;
    end else begin
      took_sample <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHAPE_KIND: kind_q <= cfg_data[2:0];
          REG_POINT_A:    pt_a <= cfg_data;
          REG_POINT_B:    pt_b <= cfg_data;
          REG_POINT_C:    pt_c <= cfg_data;
          REG_POINT_D:    pt_d <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due.sample = sample;
        due.grade = membership_grade(sample);
        grades_due.push_back(due);
        samples_taken++;
      end
      if (out_valid && !out_stall) begin
        if (grades_due.size() == 0) begin
          $display("%0t: unexpected grade transfer: expected none, actual %0d", $time, grade);
          error_count++;
        end else begin
          due = grades_due.pop_front();
          if (grade !== due.grade) begin
            $display("%0t: grade mismatch for sample %0d: expected %0d, actual %0d",
                     $time, due.sample, due.grade, grade);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_fuzzy_membership_grade_core: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Programs a whole shape; the shape code carries random upper bits.
  task automatic write_shape(input logic [2:0] kind, input int a, input int b,
                             input int c, input int d);
    logic [SW-1:0] kind_word;
    kind_word = {(SW-3)'($urandom), kind};
    shape_pts = '{a, b, c, d};
    write_reg(REG_SHAPE_KIND, kind_word);
    write_reg(REG_POINT_A, SW'(a));
    write_reg(REG_POINT_B, SW'(b));
    write_reg(REG_POINT_C, SW'(c));
    write_reg(REG_POINT_D, SW'(d));
  endtask

  task automatic queue_sample(input int x);
    samples_pending.push_back(SW'(x));
    samples_queued++;
  endtask

  // Waits until every queued sample has gone in and every grade has come out.
  task automatic settle();
    while (samples_taken != samples_queued || grades_due.size() != 0) @(negedge clk);
  endtask

  // Mostly ordered breakpoints, with small or wide spans and some misordering.
  task automatic random_shape();
    int p[4];
    int i, j, t;
    logic [2:0] kind;
    p[0] = ($urandom_range(7) == 0) ? -32768 : int'($urandom_range(65535)) - 32768;
    for (i = 1; i < 4; i++) begin
      t = ($urandom_range(3) == 0) ? int'($urandom_range(20000)) : int'($urandom_range(64));
      p[i] = p[i-1] + t;
      if (p[i] > 32767) p[i] = 32767;
    end
    if ($urandom_range(7) == 0) p[3] = 32767;
    if ($urandom_range(4) == 0) begin
      i = $urandom_range(3);
      j = $urandom_range(3);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    t = $urandom_range(9);
    kind = (t > 7) ? SHAPE_TRAPEZOID : 3'(t);
    write_shape(kind, p[0], p[1], p[2], p[3]);
  endtask

  // Samples cluster around the breakpoints, with extremes and noise mixed in.
  function automatic int pick_sample();
    int lo, hi, i;
    lo = shape_pts[0];
    hi = shape_pts[0];
    for (i = 1; i < 4; i++) begin
      if (shape_pts[i] < lo) lo = shape_pts[i];
      if (shape_pts[i] > hi) hi = shape_pts[i];
    end
    case ($urandom_range(7))
      0: return int'($urandom_range(65535));
      1: return $urandom_range(1) ? 32767 : -32768;
      2, 3, 4: return shape_pts[$urandom_range(3)] + int'($urandom_range(8)) - 4;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  initial begin
    int ph, seg, n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset shape: left shoulder with both points at zero.
    queue_sample(-32768);
    queue_sample(32767);
    queue_sample(0);
    queue_sample(-1);
    queue_sample(1);
    settle();
    // Triangle slopes both sides, feet and center.
    write_shape(SHAPE_TRIANGLE, -100, 0, 100, 0);
    queue_sample(-50);
    queue_sample(0);
    queue_sample(50);
    queue_sample(-100);
    queue_sample(100);
    settle();
    // Trapezoid spanning the whole sample range.
    write_shape(SHAPE_TRAPEZOID, -32768, -10, 10, 32767);
    queue_sample(-32767);
    queue_sample(0);
    queue_sample(32766);
    settle();
    // Right shoulder with the widest span.
    write_shape(SHAPE_RIGHT_SHOULDER, -32768, 32767, 0, 0);
    queue_sample(0);
    queue_sample(32767);
    queue_sample(-32768);
    settle();
    // Interval of one point.
    write_shape(SHAPE_INTERVAL, 5, 5, 0, 0);
    queue_sample(5);
    queue_sample(4);
    settle();
    // Singleton at the most negative value.
    write_shape(SHAPE_SINGLETON, -32768, 32767, 32767, -32768);
    queue_sample(-32768);
    queue_sample(32767);
    settle();
    // Unused shape code.
    write_shape(SHAPE_UNUSED, -1, 1, 2, 3);
    queue_sample(0);
    queue_sample(1);
    settle();

    // Random shapes under three backpressure profiles. The sender pauses
    // halfway through each shape until the pipeline has drained.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < 6; seg++) begin
        random_shape();
        repeat (2) begin
          for (n = 0; n < 18; n++) queue_sample(pick_sample());
          settle();
        end
      end
    end

    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (grades_due.size() != 0) begin
      $display("%0t: %0d grades missing: expected %0d, actual none",
               $time, grades_due.size(), grades_due[0].grade);
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_fuzzy_membership_grade_core: clean");
    end else begin
      $display("tb_fuzzy_membership_grade_core: errors");
    end
    $finish;
  end

endmodule
